### rtl/bcdxt_pkg.sv
package bcdxt_pkg;

  localparam logic [1:0] FORMAT_BC1 = 2'd0;
  localparam logic [1:0] FORMAT_BC2 = 2'd1;
  localparam logic [1:0] FORMAT_BC3 = 2'd2;

  localparam logic [1:0] CIDX_C0    = 2'd0;
  localparam logic [1:0] CIDX_C1    = 2'd1;
  localparam logic [1:0] CIDX_MIX_A = 2'd2;
  localparam logic [1:0] CIDX_MIX_B = 2'd3;

  localparam logic [2:0] AIDX_A0   = 3'd0;
  localparam logic [2:0] AIDX_A1   = 3'd1;
  localparam logic [2:0] AIDX_ZERO = 3'd6;
  localparam logic [2:0] AIDX_FULL = 3'd7;

  typedef struct packed {
    logic [63:0] rgb_blk;
    logic [63:0] alpha_block;
    logic [1:0]  texel_col;
    logic [1:0]  texel_row;
  } texel_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // x/3 for x < 768: x*683 >> 11
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = {10'd0, x} * 20'd683;
    return p[18:11];
  endfunction

  // x/5 for x < 1280: x*3277 >> 14
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = {11'd0, x} * 22'd3277;
    return p[21:14];
  endfunction

  // x/7 for x < 1792: x*2341 >> 14
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [21:0] p;
    p = {11'd0, x} * 22'd2341;
    return p[21:14];
  endfunction

endpackage

### rtl/bc_dxt_texel_decoder.sv
// Channel  | Signals                   | Handshake
// request  | req_i                     | start_i & !busy_o
// result   | res_o                     | res_valid_o, one cycle, no stall
// config   | cfg_wdata_i (block_format)| cfg_we_i
//
// One request per clock; an accepted request passes the request register and then
// the result register before res_valid_o rises with its result.
// Stage one registers the request, stage two the decoded RGBA; the decode
// logic between them sets the clock period.
// busy_o is always low. rst_ni clears the valid flags and block_format (DXT1).
// The receiver cannot stall; every result is shown for exactly one cycle.
module bc_dxt_texel_decoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  bcdxt_pkg::texel_req_t req_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_wdata_i,
  output logic                  res_valid_o,
  output bcdxt_pkg::rgba_t      res_o
);

  logic [1:0]            fmt_q;
  logic                  req_vld_q, req_vld_d;
  bcdxt_pkg::texel_req_t req_q;
  logic                  res_vld_q;
  bcdxt_pkg::rgba_t      res_q, res_d;
  bcdxt_pkg::rgb_t       rgb;
  logic [7:0]            alpha;

  assign busy_o    = 1'b0;
  assign req_vld_d = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= bcdxt_pkg::FORMAT_BC1;
      req_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fmt_q <= cfg_wdata_i;
      end
      req_vld_q <= req_vld_d;
      res_vld_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_d) begin
      req_q <= req_i;
    end
    if (req_vld_q) begin
      res_q <= res_d;
    end
  end

  bcdxt_color u_color (
    .req_i (req_q),
    .fmt_i (fmt_q),
    .rgb_o (rgb)
  );

  bcdxt_alpha u_alpha (
    .req_i   (req_q),
    .fmt_i   (fmt_q),
    .alpha_o (alpha)
  );

  assign res_d.red   = rgb.red;
  assign res_d.green = rgb.green;
  assign res_d.blue  = rgb.blue;
  assign res_d.alpha = alpha;

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

### rtl/bcdxt_color.sv
module bcdxt_color (
  input  bcdxt_pkg::texel_req_t req_i,
  input  logic [1:0]            fmt_i,
  output bcdxt_pkg::rgb_t       rgb_o
);

  logic [15:0] e0, e1;
  logic [31:0] idx;
  logic [1:0]  code;
  logic        four_col;
  logic [7:0]  c0 [3];
  logic [7:0]  c1 [3];
  logic [7:0]  res [3];

  assign e0  = req_i.rgb_blk[15:0];
  assign e1  = req_i.rgb_blk[31:16];
  assign idx = req_i.rgb_blk[63:32];
  assign code = idx[{req_i.texel_row, req_i.texel_col, 1'b0} +: 2];
  assign four_col = (e0 > e1) || (fmt_i != bcdxt_pkg::FORMAT_BC1);

  // 565 widened by shift only
  assign c0[0] = {e0[15:11], 3'b000};
  assign c0[1] = {e0[10:5], 2'b00};
  assign c0[2] = {e0[4:0], 3'b000};
  assign c1[0] = {e1[15:11], 3'b000};
  assign c1[1] = {e1[10:5], 2'b00};
  assign c1[2] = {e1[4:0], 3'b000};

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    logic [9:0] n_a, n_b;
    logic [8:0] half_sum;

    assign n_a = {1'b0, c0[ch], 1'b0} + {2'b00, c1[ch]} + 10'd1;
    assign n_b = {1'b0, c1[ch], 1'b0} + {2'b00, c0[ch]} + 10'd1;
    assign half_sum = {1'b0, c0[ch]} + {1'b0, c1[ch]};

    always_comb begin
      unique case (code)
        bcdxt_pkg::CIDX_C0: res[ch] = c0[ch];
        bcdxt_pkg::CIDX_C1: res[ch] = c1[ch];
        bcdxt_pkg::CIDX_MIX_A: res[ch] = four_col ? bcdxt_pkg::div3(n_a) : half_sum[8:1];
        bcdxt_pkg::CIDX_MIX_B: res[ch] = four_col ? bcdxt_pkg::div3(n_b) : 8'd0;
        default: res[ch] = c0[ch];
      endcase
    end
  end

  assign rgb_o.red   = res[0];
  assign rgb_o.green = res[1];
  assign rgb_o.blue  = res[2];

endmodule

### rtl/bcdxt_alpha.sv
module bcdxt_alpha (
  input  bcdxt_pkg::texel_req_t req_i,
  input  logic [1:0]            fmt_i,
  output logic [7:0]            alpha_o
);

  logic [63:0] ab;
  logic [3:0]  pos;
  logic [5:0]  kpos;
  logic [47:0] codes;
  logic [3:0]  nib;
  logic [2:0]  k;
  logic [7:0]  a0, a1;
  logic [2:0]  w0_7, w1, w0_5;
  logic [10:0] n7, n5;
  logic [7:0]  a5;

  assign ab    = req_i.alpha_block;
  assign pos   = {req_i.texel_row, req_i.texel_col};
  assign kpos  = {1'b0, pos, 1'b0} + {2'b00, pos};
  assign codes = ab[63:16];
  assign k     = codes[kpos +: 3];
  assign nib   = ab[{req_i.texel_row, req_i.texel_col, 2'b00} +: 4];
  assign a0    = ab[7:0];
  assign a1    = ab[15:8];

  assign w0_7 = 3'd0 - k;          // 8 - k, k >= 2
  assign w1   = k - 3'd1;
  assign w0_5 = 3'd6 - k;

  assign n7 = {3'd0, a0} * {8'd0, w0_7} + {3'd0, a1} * {8'd0, w1} + 11'd3;
  assign n5 = {3'd0, a0} * {8'd0, w0_5} + {3'd0, a1} * {8'd0, w1} + 11'd2;

  always_comb begin
    if (k == bcdxt_pkg::AIDX_ZERO) begin
      a5 = 8'd0;
    end else if (k == bcdxt_pkg::AIDX_FULL) begin
      a5 = 8'hFF;
    end else begin
      a5 = bcdxt_pkg::div5(n5);
    end
  end

  always_comb begin
    priority if (fmt_i == bcdxt_pkg::FORMAT_BC1) begin
      alpha_o = 8'hFF;
    end else if (fmt_i == bcdxt_pkg::FORMAT_BC2) begin
      alpha_o = {nib, 4'b0000};
    end else if (k == bcdxt_pkg::AIDX_A0) begin
      alpha_o = a0;
    end else if (k == bcdxt_pkg::AIDX_A1) begin
      alpha_o = a1;
    end else if (a0 > a1) begin
      alpha_o = bcdxt_pkg::div7(n7);
    end else begin
      alpha_o = a5;
    end
  end

endmodule

### verif/tb_bc_dxt_texel_decoder.sv
`timescale 1ns / 1ps

module tb_bc_dxt_texel_decoder;

  localparam logic [1:0] FMT_UNUSED     = 2'd3;  // decodes as DXT5
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         RAND_PHASES    = 8;
  localparam int         RAND_PER_PHASE = 75;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  bcdxt_pkg::texel_req_t req       = '0;
  logic                  cfg_we    = 1'b0;
  logic [1:0]            cfg_wdata = bcdxt_pkg::FORMAT_BC1;
  logic                  res_valid;
  bcdxt_pkg::rgba_t      res;

  bcdxt_pkg::texel_req_t texel_req_q[$];
  bcdxt_pkg::rgba_t      rgba_expect_q[$];
  logic [1:0]            fmt_shadow  = bcdxt_pkg::FORMAT_BC1;
  logic                  req_taken   = 1'b0;
  bit                    gaps_on     = 1'b1;
  int                    gap_left    = 0;
  int                    idle_cycles = 0;
  int                    mismatches  = 0;

  bc_dxt_texel_decoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always #5 clk = ~clk;

  function automatic bcdxt_pkg::rgba_t decode_texel(bcdxt_pkg::texel_req_t r,
                                                    logic [1:0] fmt);
    logic [15:0]      e0;
    logic [15:0]      e1;
    logic [1:0]       cidx;
    logic [2:0]       aidx;
    int unsigned      c0[3];
    int unsigned      c1[3];
    int unsigned      mix[3];
    int unsigned      a0;
    int unsigned      a1;
    int unsigned      k;
    int unsigned      alpha;
    bit               four_colour;
    bcdxt_pkg::rgba_t t;
    e0    = r.rgb_blk[15:0];
    e1    = r.rgb_blk[31:16];
    cidx  = r.rgb_blk[32 + 8 * int'(r.texel_row) + 2 * int'(r.texel_col) +: 2];
    c0[0] = {e0[15:11], 3'b000};
    c0[1] = {e0[10:5], 2'b00};
    c0[2] = {e0[4:0], 3'b000};
    c1[0] = {e1[15:11], 3'b000};
    c1[1] = {e1[10:5], 2'b00};
    c1[2] = {e1[4:0], 3'b000};
    four_colour = (e0 > e1) || (fmt != bcdxt_pkg::FORMAT_BC1);
    for (int i = 0; i < 3; i++) begin
      case (cidx)
        bcdxt_pkg::CIDX_C0:    mix[i] = c0[i];
        bcdxt_pkg::CIDX_C1:    mix[i] = c1[i];
        bcdxt_pkg::CIDX_MIX_A:
          mix[i] = four_colour ? (2 * c0[i] + c1[i] + 1) / 3 : (c0[i] + c1[i]) / 2;
        bcdxt_pkg::CIDX_MIX_B:
          mix[i] = four_colour ? (c0[i] + 2 * c1[i] + 1) / 3 : 0;
      endcase
    end
    if (fmt == bcdxt_pkg::FORMAT_BC1) begin
      alpha = 255;
    end else if (fmt == bcdxt_pkg::FORMAT_BC2) begin
      alpha = 16 * r.alpha_block[16 * int'(r.texel_row) + 4 * int'(r.texel_col) +: 4];
    end else begin
      a0    = r.alpha_block[7:0];
      a1    = r.alpha_block[15:8];
      aidx  = r.alpha_block[16 + 3 * (4 * int'(r.texel_row) + int'(r.texel_col)) +: 3];
      k     = aidx;
      if (aidx == bcdxt_pkg::AIDX_A0) alpha = a0;
      else if (aidx == bcdxt_pkg::AIDX_A1) alpha = a1;
      else if (a0 > a1) alpha = ((8 - k) * a0 + (k - 1) * a1 + 3) / 7;
      else if (aidx == bcdxt_pkg::AIDX_ZERO) alpha = 0;
      else if (aidx == bcdxt_pkg::AIDX_FULL) alpha = 255;
      else alpha = ((6 - k) * a0 + (k - 1) * a1 + 2) / 5;
    end
    t.red   = 8'(mix[0]);
    t.green = 8'(mix[1]);
    t.blue  = 8'(mix[2]);
    t.alpha = 8'(alpha);
    return t;
  endfunction

  function automatic bcdxt_pkg::texel_req_t texel_at(logic [63:0] cb, logic [63:0] ab,
                                                     int col, int row);
    bcdxt_pkg::texel_req_t r;
    r.rgb_blk     = cb;
    r.alpha_block = ab;
    r.texel_col   = 2'(col);
    r.texel_row   = 2'(row);
    return r;
  endfunction

  function automatic bcdxt_pkg::texel_req_t random_texel();
    bcdxt_pkg::texel_req_t r;
    r.rgb_blk     = {$urandom, $urandom};
    r.alpha_block = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: r.rgb_blk[31:16]     = r.rgb_blk[15:0];
      1: r.alpha_block[15:8]  = r.alpha_block[7:0];
      default: ;
    endcase
    r.texel_col = 2'($urandom_range(0, 3));
    r.texel_row = 2'($urandom_range(0, 3));
    return r;
  endfunction

  task automatic check_channel(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // driver: requests change on the falling edge
  always @(negedge clk) begin
    if (req_taken) texel_req_q.pop_front();
    if (gap_left != 0) begin
      gap_left = gap_left - 1;
      start <= 1'b0;
    end else if (texel_req_q.size() == 0) begin
      start <= 1'b0;
    end else if (gaps_on && (!start || req_taken) && $urandom_range(0, 5) == 0) begin
      gap_left = $urandom_range(0, 8);
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      req   <= texel_req_q[0];
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst_n) begin
      req_taken <= start && !busy;
      if (cfg_we) fmt_shadow <= cfg_wdata;
      if (start && !busy) rgba_expect_q.push_back(decode_texel(req, fmt_shadow));
      if (res_valid) begin
        if (rgba_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got %h", $time, res);
        end else begin
          check_channel("red",   rgba_expect_q[0].red,   res.red);
          check_channel("green", rgba_expect_q[0].green, res.green);
          check_channel("blue",  rgba_expect_q[0].blue,  res.blue);
          check_channel("alpha", rgba_expect_q[0].alpha, res.alpha);
          rgba_expect_q.pop_front();
        end
      end
      if ((start && !busy) || res_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (texel_req_q.size() != 0 || start || rgba_expect_q.size() != 0);
  endtask

  task automatic set_format(logic [1:0] fmt);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= fmt;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [63:0] acodes;
    logic [1:0]  fmt;
    acodes = '0;
    for (int t = 0; t < 16; t++) acodes[16 + 3 * t +: 3] = 3'(t);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // DXT1 after reset: four-colour, three-colour, equal endpoints
    for (int c = 0; c < 4; c++)
      texel_req_q.push_back(texel_at({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, '1, c, 0));
    for (int c = 0; c < 4; c++)
      texel_req_q.push_back(texel_at({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, '1, c, 2));
    texel_req_q.push_back(texel_at('1, '0, 3, 3));

    // DXT3: four-colour despite e0 < e1, nibble order
    set_format(bcdxt_pkg::FORMAT_BC2);
    texel_req_q.push_back(texel_at({32'h1B1B1B1B, 16'hF81F, 16'h07E0},
                                   64'hFEDC_BA98_7654_3210, 0, 0));
    texel_req_q.push_back(texel_at({32'h1B1B1B1B, 16'hF81F, 16'h07E0},
                                   64'hFEDC_BA98_7654_3210, 1, 0));
    texel_req_q.push_back(texel_at({32'h1B1B1B1B, 16'hF81F, 16'h07E0},
                                   64'hFEDC_BA98_7654_3210, 2, 1));
    texel_req_q.push_back(texel_at({32'h1B1B1B1B, 16'hF81F, 16'h07E0},
                                   64'hFEDC_BA98_7654_3210, 3, 3));

    // DXT5: eight-step then six-step alpha
    set_format(bcdxt_pkg::FORMAT_BC3);
    for (int t = 0; t < 8; t++)
      texel_req_q.push_back(texel_at({$urandom, $urandom}, acodes | 64'h10F0, t % 4, t / 4));
    for (int t = 2; t < 8; t++)
      if (t != 3 && t != 4)
        texel_req_q.push_back(texel_at({$urandom, $urandom}, acodes | 64'hE020,
                                       t % 4, t / 4));

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       fmt = FMT_UNUSED;
        1:       fmt = bcdxt_pkg::FORMAT_BC1;
        2:       fmt = bcdxt_pkg::FORMAT_BC2;
        3:       fmt = bcdxt_pkg::FORMAT_BC3;
        default: fmt = 2'($urandom_range(0, 3));
      endcase
      set_format(fmt);
      gaps_on = (ph != RAND_PHASES - 1);
      for (int n = 0; n < RAND_PER_PHASE; n++) texel_req_q.push_back(random_texel());
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
